// ----- rtl/assert_macros.svh -----
// Assertion helpers included by the RTL top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on clk and switched off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Concurrent check that a condition never holds.
`define ASSERT_NEVER(label, cond, msg) \
	`ASSERT_CLK(label, !(cond), msg)

`endif

// ----- rtl/dfm_pkg.sv -----
package dfm_pkg;

	// Field widths.
	localparam int VOLT_W      = 16;
	localparam int TEMP_W      = 16;
	localparam int SPEED_W     = 16;
	localparam int CUR_W       = 16;
	localparam int SQ_W        = 32;
	localparam int LIMIT_W     = 39;
	localparam int ACC_W       = 40;
	localparam int NUM_FAULTS  = 9;
	localparam int NUM_CHECKS  = 7;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 39;

	// Default parameter values.
	localparam int DEF_DC_COUNT       = 10;
	localparam int DEF_TEMP_COUNT     = 100;
	localparam int DEF_RPM_COUNT      = 10;
	localparam int DEF_RPM_LIMIT      = 3000;
	localparam int DEF_CLEARABLE_MASK = 511;

	// Register reset values.
	localparam logic [VOLT_W-1:0]         RST_DC_UPPER   = 16'd4000;
	localparam logic [VOLT_W-1:0]         RST_DC_LOWER   = 16'd1000;
	localparam logic signed [TEMP_W-1:0]  RST_DEV_UPPER  = 16'sd900;
	localparam logic signed [TEMP_W-1:0]  RST_DEV_LOWER  = -16'sd200;
	localparam logic signed [TEMP_W-1:0]  RST_DSP_UPPER  = 16'sd850;
	localparam logic signed [TEMP_W-1:0]  RST_DSP_LOWER  = -16'sd200;
	localparam logic [SQ_W-1:0]           RST_CONT_SQ    = '0;
	localparam logic [LIMIT_W-1:0]        RST_OVL_LIMIT  = '1;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DC_UPPER   = 3'd0,
		REG_DC_LOWER   = 3'd1,
		REG_DEV_UPPER  = 3'd2,
		REG_DEV_LOWER  = 3'd3,
		REG_DSP_UPPER  = 3'd4,
		REG_DSP_LOWER  = 3'd5,
		REG_CONT_SQ    = 3'd6,
		REG_OVL_LIMIT  = 3'd7
	} cfg_reg_t;

	// Request types.
	typedef enum logic {
		REQ_CHECK = 1'b0,
		REQ_CLEAR = 1'b1
	} req_type_t;

	// Fault bit positions.
	localparam int FB_OV       = 0;
	localparam int FB_UV       = 1;
	localparam int FB_DEV_HOT  = 2;
	localparam int FB_DEV_COLD = 3;
	localparam int FB_DSP_HOT  = 4;
	localparam int FB_DSP_COLD = 5;
	localparam int FB_RPM      = 6;
	localparam int FB_OVERLOAD = 7;
	localparam int FB_PHASE    = 8;

	typedef logic [NUM_FAULTS-1:0] fault_t;

endpackage

// ----- rtl/dfm_chk_if.sv -----
interface dfm_chk_if import dfm_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic                       req_type;
	logic [VOLT_W-1:0]          dc_link;
	logic signed [TEMP_W-1:0]   pwr_temp;
	logic signed [TEMP_W-1:0]   ctrl_temp;
	logic signed [SPEED_W-1:0]  speed_ref;
	logic signed [CUR_W-1:0]    current_a;
	logic signed [CUR_W-1:0]    current_b;
	logic                       phase_found;

	modport source (
		output valid, req_type, dc_link, pwr_temp, ctrl_temp, speed_ref,
			current_a, current_b, phase_found,
		input  ready
	);
	modport sink (
		input  valid, req_type, dc_link, pwr_temp, ctrl_temp, speed_ref,
			current_a, current_b, phase_found,
		output ready
	);
endinterface

// ----- rtl/dfm_res_if.sv -----
interface dfm_res_if import dfm_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [NUM_FAULTS-1:0]  fault_flags;
	logic                   servo_disable;

	modport source (output valid, fault_flags, servo_disable, input ready);
	modport sink (input valid, fault_flags, servo_disable, output ready);
endinterface

// ----- rtl/dfm_cfg_if.sv -----
interface dfm_cfg_if import dfm_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CFG_IDX_W-1:0]   index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/drive_fault_monitor_top.sv -----
// Drive fault monitor.
// The chk channel takes one request per control period: a periodic check with
// DC link voltage, two temperatures, commanded speed, two phase currents and the
// phase-found flag, or a clear request that masks the resettable faults.
// The res channel returns exactly one result per request: the nine fault flags
// after that request and the servo disable request.
// The cfg channel writes the eight limit registers and is always ready; the user
// writes it only while no request is in flight, which the block does not enforce.
// A request passes stage 1, stage 2 and the result register before its result
// is valid. A request can be accepted in every cycle while the receiver keeps up;
// the debounce counters and the overload accumulator close their loop within the
// commit stage, which allows that rate. The stages hold valid bits, so a stalled
// receiver only stops the stages behind a full one: up to two more requests are
// accepted while a result waits. Reset loads the register defaults, clears
// counters, accumulator and faults, and empties the pipeline.
module drive_fault_monitor_top import dfm_pkg::*; #(
	parameter int DC_COUNT       = DEF_DC_COUNT,
	parameter int TEMP_COUNT     = DEF_TEMP_COUNT,
	parameter int RPM_COUNT      = DEF_RPM_COUNT,
	parameter int RPM_LIMIT      = DEF_RPM_LIMIT,
	parameter int CLEARABLE_MASK = DEF_CLEARABLE_MASK
) (
	input logic        clk,
	input logic        arst_n,
	dfm_chk_if.sink    chk,
	dfm_res_if.source  res,
	dfm_cfg_if.sink    cfg
);

`include "assert_macros.svh"

	localparam logic signed [SPEED_W-1:0] RPM_POS = SPEED_W'(RPM_LIMIT);
	localparam logic signed [SPEED_W-1:0] RPM_NEG = -RPM_POS;
	localparam fault_t CLR_MASK = NUM_FAULTS'(CLEARABLE_MASK);

	// Configuration registers.
	logic [VOLT_W-1:0]         dc_upper_q, dc_lower_q;
	logic signed [TEMP_W-1:0]  dev_upper_q, dev_lower_q, dsp_upper_q, dsp_lower_q;
	logic [SQ_W-1:0]           cont_sq_q;
	logic [LIMIT_W-1:0]        ovl_limit_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_upper_q  <= RST_DC_UPPER;
			dc_lower_q  <= RST_DC_LOWER;
			dev_upper_q <= RST_DEV_UPPER;
			dev_lower_q <= RST_DEV_LOWER;
			dsp_upper_q <= RST_DSP_UPPER;
			dsp_lower_q <= RST_DSP_LOWER;
			cont_sq_q   <= RST_CONT_SQ;
			ovl_limit_q <= RST_OVL_LIMIT;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_DC_UPPER:  dc_upper_q  <= cfg.data[VOLT_W-1:0];
				REG_DC_LOWER:  dc_lower_q  <= cfg.data[VOLT_W-1:0];
				REG_DEV_UPPER: dev_upper_q <= cfg.data[TEMP_W-1:0];
				REG_DEV_LOWER: dev_lower_q <= cfg.data[TEMP_W-1:0];
				REG_DSP_UPPER: dsp_upper_q <= cfg.data[TEMP_W-1:0];
				REG_DSP_LOWER: dsp_lower_q <= cfg.data[TEMP_W-1:0];
				REG_CONT_SQ:   cont_sq_q   <= cfg.data[SQ_W-1:0];
				REG_OVL_LIMIT: ovl_limit_q <= cfg.data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage handshake: each stage moves when the one ahead has room.
	logic v_s1, v_s2, out_v_q;
	logic rdy_out, rdy_s2, rdy_s1;
	logic commit;

	assign rdy_out   = !out_v_q || res.ready;
	assign rdy_s2    = !v_s2 || rdy_out;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign chk.ready = rdy_s1;
	assign commit    = v_s2 && rdy_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= chk.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_out) out_v_q <= v_s2;
		end
	end

	// Stage 1: capture the request.
	logic                       req_s1, found_s1;
	logic [VOLT_W-1:0]          dc_s1;
	logic signed [TEMP_W-1:0]   dev_s1, dsp_s1;
	logic signed [SPEED_W-1:0]  spd_s1;
	logic signed [CUR_W-1:0]    ia_s1, ib_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1 && chk.valid) begin
			req_s1   <= chk.req_type;
			found_s1 <= chk.phase_found;
			dc_s1    <= chk.dc_link;
			dev_s1   <= chk.pwr_temp;
			dsp_s1   <= chk.ctrl_temp;
			spd_s1   <= chk.speed_ref;
			ia_s1    <= chk.current_a;
			ib_s1    <= chk.current_b;
		end
	end

	// Stage 2: limit compares and the squared current magnitude.
	logic [NUM_CHECKS-1:0]  exc_c;
	logic signed [2*CUR_W-1:0] sqa_c, sqb_c;
	logic [SQ_W-1:0]        sq_c;

	always_comb begin
		exc_c[FB_OV]       = dc_s1 > dc_upper_q;
		exc_c[FB_UV]       = dc_s1 < dc_lower_q;
		exc_c[FB_DEV_HOT]  = dev_s1 > dev_upper_q;
		exc_c[FB_DEV_COLD] = dev_s1 < dev_lower_q;
		exc_c[FB_DSP_HOT]  = dsp_s1 > dsp_upper_q;
		exc_c[FB_DSP_COLD] = dsp_s1 < dsp_lower_q;
		exc_c[FB_RPM]      = (spd_s1 > RPM_POS) || (spd_s1 < RPM_NEG);
		sqa_c = ia_s1 * ia_s1;
		sqb_c = ib_s1 * ib_s1;
		sq_c  = SQ_W'($unsigned(sqa_c)) + SQ_W'($unsigned(sqb_c));
	end

	logic                   req_s2, found_s2;
	logic [NUM_CHECKS-1:0]  exc_s2;
	logic [SQ_W-1:0]        sq_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			req_s2   <= req_s1;
			found_s2 <= found_s1;
			exc_s2   <= exc_c;
			sq_s2    <= sq_c;
		end
	end

	// Commit stage: debounce counters, one per limit check.
	logic [NUM_CHECKS-1:0] hit_c;
	logic check_commit;

	assign check_commit = commit && (req_type_t'(req_s2) == REQ_CHECK);

	for (genvar i = 0; i < NUM_CHECKS; i++) begin : g_deb
		localparam int LIM = (i <= FB_UV) ? DC_COUNT :
			(i <= FB_DSP_COLD) ? TEMP_COUNT : RPM_COUNT;
		localparam int CW = $clog2(LIM + 1);

		logic [CW-1:0] cnt_q, cnt_d;

		always_comb begin
			if (!exc_s2[i]) begin
				cnt_d = '0;
			end else if (cnt_q == CW'(LIM)) begin
				cnt_d = cnt_q;
			end else begin
				cnt_d = cnt_q + CW'(1);
			end
		end

		assign hit_c[i] = (cnt_d == CW'(LIM));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cnt_q <= '0;
			end else if (check_commit) begin
				cnt_q <= cnt_d;
			end
		end
	end

	// Overload accumulator: add the squared current less the rating, clamp at
	// zero and at full scale, and clear on a trip.
	logic [ACC_W-1:0]  acc_q, acc_sat, acc_d;
	logic [ACC_W:0]    acc_sum;
	logic [ACC_W+1:0]  acc_diff;
	logic              ovl_c;

	always_comb begin
		acc_sum  = {1'b0, acc_q} + (ACC_W+1)'(sq_s2);
		acc_diff = {1'b0, acc_sum} - (ACC_W+2)'(cont_sq_q);
		if (acc_diff[ACC_W+1]) begin
			acc_sat = '0;
		end else if (acc_diff[ACC_W]) begin
			acc_sat = '1;
		end else begin
			acc_sat = acc_diff[ACC_W-1:0];
		end
		ovl_c = acc_sat > ACC_W'(ovl_limit_q);
		acc_d = ovl_c ? '0 : acc_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (check_commit) begin
			acc_q <= acc_d;
		end
	end

	// Sticky fault bits and the disable request.
	fault_t fault_q, fault_d;
	logic   disable_d;

	always_comb begin
		fault_d   = fault_q;
		disable_d = 1'b0;
		if (req_type_t'(req_s2) == REQ_CLEAR) begin
			fault_d = fault_q & CLR_MASK;
		end else begin
			fault_d = fault_q | NUM_FAULTS'(hit_c);
			fault_d[FB_OVERLOAD] = fault_q[FB_OVERLOAD] | ovl_c;
			if ((fault_d != '0) && !found_s2) begin
				fault_d[FB_PHASE] = 1'b1;
				disable_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_q <= '0;
		end else if (commit) begin
			fault_q <= fault_d;
		end
	end

	// Result register.
	fault_t flags_q;
	logic   servo_q;

	always_ff @(posedge clk) begin
		if (commit) begin
			flags_q <= fault_d;
			servo_q <= disable_d;
		end
	end

	assign res.valid         = out_v_q;
	assign res.fault_flags   = flags_q;
	assign res.servo_disable = servo_q;

	// A disable request always comes with the phase-finding fault.
	`ASSERT_NEVER(a_disable_has_phase, res.valid && res.servo_disable && !res.fault_flags[FB_PHASE], "servo disable without phase fault")
	// A periodic check never drops a fault bit.
	`ASSERT_CLK(a_faults_sticky, check_commit |=> ((fault_q & $past(fault_q)) == $past(fault_q)), "fault bit lost on check")
	// After a check the accumulator never sits above the trip level.
	`ASSERT_CLK(a_acc_bounded, check_commit |=> (acc_q <= ACC_W'(ovl_limit_q)), "accumulator above trip level")
	// The result register mirrors the fault state it was loaded from.
	`ASSERT_CLK(a_result_matches, commit |=> (res.fault_flags == fault_q), "result differs from fault state")

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import dfm_pkg::*;

	localparam int     CYCLE_LIMIT = 200000;
	localparam longint ACC_MAX     = 64'h0000_00FF_FFFF_FFFF;

	localparam logic [CFG_DATA_W-1:0] KEEP_16 = 39'h00_0000_FFFF;
	localparam logic [CFG_DATA_W-1:0] KEEP_32 = 39'h00_FFFF_FFFF;
	localparam logic [CFG_DATA_W-1:0] KEEP_39 = '1;

	// One request on the check channel.
	typedef struct {
		req_type_t                 kind;
		logic [VOLT_W-1:0]         dc_link;
		logic signed [TEMP_W-1:0]  pwr_temp;
		logic signed [TEMP_W-1:0]  ctrl_temp;
		logic signed [SPEED_W-1:0] speed_ref;
		logic signed [CUR_W-1:0]   current_a;
		logic signed [CUR_W-1:0]   current_b;
		logic                      phase_found;
	} check_req_t;

	// One result on the result channel.
	typedef struct {
		fault_t flags;
		logic   servo_disable;
	} fault_result_t;

	logic clk;
	logic arst_n;

	dfm_chk_if chk ();
	dfm_res_if res ();
	dfm_cfg_if cfg ();

	drive_fault_monitor_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.chk    (chk),
		.res    (res),
		.cfg    (cfg)
	);

	// Requests waiting to be offered and results still owed by the block.
	check_req_t    check_queue [$];
	fault_result_t flags_due [$];

	// Shadow copy of the limit registers.
	logic [VOLT_W-1:0]        lim_dc_upper;
	logic [VOLT_W-1:0]        lim_dc_lower;
	logic signed [TEMP_W-1:0] lim_dev_upper;
	logic signed [TEMP_W-1:0] lim_dev_lower;
	logic signed [TEMP_W-1:0] lim_dsp_upper;
	logic signed [TEMP_W-1:0] lim_dsp_lower;
	logic [SQ_W-1:0]          lim_cont_sq;
	logic [LIMIT_W-1:0]       lim_overload;

	// Shadow copy of the debounce counters, accumulator and sticky faults.
	logic [7:0]       trip_cnt [NUM_CHECKS];
	logic [ACC_W-1:0] i2t_accum;
	fault_t           fault_state;

	logic chk_fire  = 1'b0;
	logic quiet     = 1'b0;
	logic res_hold  = 1'b0;
	int   send_gap  = 0;
	int   sink_gap  = 0;
	int   n_accepted = 0;
	int   errors    = 0;
	int   cycle_cnt = 0;

	// Clock generation.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Uniform integer in [lo, hi].
	function automatic int rnd_in(int lo, int hi);
		if (hi <= lo) begin
			return lo;
		end
		return lo + int'($urandom_range(hi - lo));
	endfunction

	// Picks a level above the upper limit, below the lower limit, or between them.
	function automatic int pick_level(int lo_lim, int hi_lim, int floor_v, int ceil_v,
			bit want_hi, bit want_lo);
		if (want_hi && hi_lim < ceil_v) begin
			return rnd_in(hi_lim + 1, ceil_v);
		end
		if (want_lo && lo_lim > floor_v) begin
			return rnd_in(floor_v, lo_lim - 1);
		end
		if (lo_lim <= hi_lim) begin
			return rnd_in(lo_lim, hi_lim);
		end
		return rnd_in(floor_v, ceil_v);
	endfunction

	// A check request shaped to exceed the limits selected by trip; of a pair, only the upper one when both are set.
	function automatic check_req_t shaped_check(logic [NUM_CHECKS-1:0] trip, bit heavy,
			bit found);
		check_req_t it;
		int         spd;
		it.kind        = REQ_CHECK;
		it.dc_link     = 16'(pick_level(lim_dc_lower, lim_dc_upper, 0, 65535,
			trip[FB_OV], trip[FB_UV]));
		it.pwr_temp    = 16'(pick_level(lim_dev_lower, lim_dev_upper, -32768, 32767,
			trip[FB_DEV_HOT], trip[FB_DEV_COLD]));
		it.ctrl_temp   = 16'(pick_level(lim_dsp_lower, lim_dsp_upper, -32768, 32767,
			trip[FB_DSP_HOT], trip[FB_DSP_COLD]));
		if (trip[FB_RPM]) begin
			spd = rnd_in(DEF_RPM_LIMIT + 1, 32768);
			if ($urandom_range(1) == 0) begin
				spd = -spd;
			end
		end else begin
			spd = rnd_in(-DEF_RPM_LIMIT, DEF_RPM_LIMIT);
		end
		it.speed_ref   = 16'(spd);
		it.current_a   = heavy ? 16'($urandom) : 16'(rnd_in(-300, 300));
		it.current_b   = heavy ? 16'($urandom) : 16'(rnd_in(-300, 300));
		it.phase_found = found;
		return it;
	endfunction

	// A request with every field drawn at random.
	function automatic check_req_t noise_req();
		check_req_t it;
		it.kind        = req_type_t'($urandom_range(1));
		it.dc_link     = 16'($urandom);
		it.pwr_temp    = 16'($urandom);
		it.ctrl_temp   = 16'($urandom);
		it.speed_ref   = 16'($urandom);
		it.current_a   = 16'($urandom);
		it.current_b   = 16'($urandom);
		it.phase_found = 1'($urandom_range(1));
		return it;
	endfunction

	// A check request with all readings comfortably inside the default limits.
	function automatic check_req_t nominal_check();
		check_req_t it;
		it.kind        = REQ_CHECK;
		it.dc_link     = 16'd2000;
		it.pwr_temp    = 16'sd250;
		it.ctrl_temp   = 16'sd250;
		it.speed_ref   = '0;
		it.current_a   = '0;
		it.current_b   = '0;
		it.phase_found = 1'b1;
		return it;
	endfunction

	// Updates the shadow state for one request and returns the result it owes.
	function automatic fault_result_t predict_faults(check_req_t it);
		fault_result_t          r;
		logic [NUM_CHECKS-1:0]  over;
		int                     spd;
		int                     lim;
		longint                 ia;
		longint                 ib;
		longint                 acc;
		r.servo_disable = 1'b0;
		if (it.kind == REQ_CLEAR) begin
			// Counters and the accumulator hold across a clear.
			fault_state = fault_state & fault_t'(DEF_CLEARABLE_MASK);
		end else begin
			spd = it.speed_ref;
			if (spd < 0) begin
				spd = -spd;
			end
			over[FB_OV]       = it.dc_link > lim_dc_upper;
			over[FB_UV]       = it.dc_link < lim_dc_lower;
			over[FB_DEV_HOT]  = it.pwr_temp > lim_dev_upper;
			over[FB_DEV_COLD] = it.pwr_temp < lim_dev_lower;
			over[FB_DSP_HOT]  = it.ctrl_temp > lim_dsp_upper;
			over[FB_DSP_COLD] = it.ctrl_temp < lim_dsp_lower;
			over[FB_RPM]      = spd > DEF_RPM_LIMIT;

			// The seven debounced checks own fault bits 0 through 6 in order.
			for (int i = 0; i < NUM_CHECKS; i++) begin
				lim = (i < 2) ? DEF_DC_COUNT : (i < 6) ? DEF_TEMP_COUNT : DEF_RPM_COUNT;
				if (over[i]) begin
					if (trip_cnt[i] < lim) begin
						trip_cnt[i] = trip_cnt[i] + 8'd1;
					end
				end else begin
					trip_cnt[i] = '0;
				end
				if (trip_cnt[i] >= lim) begin
					trip_cnt[i]    = 8'(lim);
					fault_state[i] = 1'b1;
				end
			end

			// Overload accumulator, clamped at zero and saturated at its width.
			ia  = it.current_a;
			ib  = it.current_b;
			acc = longint'(i2t_accum) + ia * ia + ib * ib - longint'(lim_cont_sq);
			if (acc < 0) begin
				acc = 0;
			end
			if (acc > ACC_MAX) begin
				acc = ACC_MAX;
			end
			i2t_accum = acc[ACC_W-1:0];
			if (i2t_accum > lim_overload) begin
				fault_state[FB_OVERLOAD] = 1'b1;
				i2t_accum                = '0;
			end

			// Any fault before phase finding has completed disables the servo.
			if (fault_state != '0 && !it.phase_found) begin
				fault_state[FB_PHASE] = 1'b1;
				r.servo_disable       = 1'b1;
			end
		end
		r.flags = fault_state;
		return r;
	endfunction

	// Writes one limit register, with random junk above the register's width.
	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value,
			logic [CFG_DATA_W-1:0] keep);
		logic [CFG_DATA_W-1:0] junk;
		logic [CFG_DATA_W-1:0] word;
		junk = CFG_DATA_W'({$urandom, $urandom});
		if ($urandom_range(1) == 0) begin
			junk = '0;
		end
		word = (value & keep) | (junk & ~keep);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= word;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			REG_DC_UPPER:  lim_dc_upper  = word[VOLT_W-1:0];
			REG_DC_LOWER:  lim_dc_lower  = word[VOLT_W-1:0];
			REG_DEV_UPPER: lim_dev_upper = word[TEMP_W-1:0];
			REG_DEV_LOWER: lim_dev_lower = word[TEMP_W-1:0];
			REG_DSP_UPPER: lim_dsp_upper = word[TEMP_W-1:0];
			REG_DSP_LOWER: lim_dsp_lower = word[TEMP_W-1:0];
			REG_CONT_SQ:   lim_cont_sq   = word[SQ_W-1:0];
			REG_OVL_LIMIT: lim_overload  = word[LIMIT_W-1:0];
			default: ;
		endcase
	endtask

	// Programs the full set of limits; called only while the block is idle.
	task automatic set_limits(int dc_up, int dc_lo, int dev_up, int dev_lo, int dsp_up,
			int dsp_lo, logic [SQ_W-1:0] cont_sq, logic [LIMIT_W-1:0] ovl);
		write_reg(REG_DC_UPPER, CFG_DATA_W'(dc_up), KEEP_16);
		write_reg(REG_DC_LOWER, CFG_DATA_W'(dc_lo), KEEP_16);
		write_reg(REG_DEV_UPPER, CFG_DATA_W'(dev_up), KEEP_16);
		write_reg(REG_DEV_LOWER, CFG_DATA_W'(dev_lo), KEEP_16);
		write_reg(REG_DSP_UPPER, CFG_DATA_W'(dsp_up), KEEP_16);
		write_reg(REG_DSP_LOWER, CFG_DATA_W'(dsp_lo), KEEP_16);
		write_reg(REG_CONT_SQ, CFG_DATA_W'(cont_sq), KEEP_32);
		write_reg(REG_OVL_LIMIT, CFG_DATA_W'(ovl), KEEP_39);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// Queues runs of requests that hold a chosen set of limits exceeded.
	task automatic queue_episodes(int count);
		int                    n;
		int                    len;
		bit                    long_run;
		bit                    heavy;
		bit                    found;
		logic [NUM_CHECKS-1:0] trip;
		check_req_t            it;
		@(posedge clk);
		n = 0;
		while (n < count) begin
			long_run = ($urandom_range(7) == 0);
			len      = long_run ? $urandom_range(130, 90) : $urandom_range(16, 1);
			heavy    = ($urandom_range(2) == 0);
			found    = ($urandom_range(7) != 0);
			for (int b = 0; b < NUM_CHECKS; b++) begin
				trip[b] = long_run ? 1'($urandom_range(1)) : ($urandom_range(3) == 0);
			end
			repeat (len) begin
				it = shaped_check(trip, heavy, found);
				if (long_run) begin
					// Clear requests leave the counters alone, so a long run survives them.
					if ($urandom_range(39) == 0) begin
						it.kind = REQ_CLEAR;
					end
				end else begin
					case ($urandom_range(19))
						0:       it.kind = REQ_CLEAR;
						1, 2:    it = noise_req();
						default: ;
					endcase
				end
				check_queue.push_back(it);
				n++;
			end
		end
	endtask

	// Waits until every queued request has been taken and answered.
	task automatic drain();
		do @(posedge clk); while (check_queue.size() != 0 || flags_due.size() != 0);
	endtask

	// Request driver: holds an offered request until it is taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			chk.valid <= 1'b0;
		end else if (chk.valid && !chk_fire) begin
		end else if (send_gap > 0) begin
			send_gap  = send_gap - 1;
			chk.valid <= 1'b0;
		end else if (check_queue.size() == 0) begin
			chk.valid <= 1'b0;
		end else if (!quiet && $urandom_range(5) == 0) begin
			send_gap  = $urandom_range(12, 1) - 1;
			chk.valid <= 1'b0;
		end else begin
			chk.valid       <= 1'b1;
			chk.req_type    <= check_queue[0].kind;
			chk.dc_link     <= check_queue[0].dc_link;
			chk.pwr_temp    <= check_queue[0].pwr_temp;
			chk.ctrl_temp   <= check_queue[0].ctrl_temp;
			chk.speed_ref   <= check_queue[0].speed_ref;
			chk.current_a   <= check_queue[0].current_a;
			chk.current_b   <= check_queue[0].current_b;
			chk.phase_found <= check_queue[0].phase_found;
		end
	end

	// Result receiver: random stalls, plus the long hold-off.
	always @(negedge clk) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else if (res_hold) begin
			res.ready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap  = sink_gap - 1;
			res.ready <= 1'b0;
		end else if (!quiet && $urandom_range(5) == 0) begin
			sink_gap  = $urandom_range(12, 1) - 1;
			res.ready <= 1'b0;
		end else begin
			res.ready <= 1'b1;
		end
	end

	// Long receiver hold-off so the pipeline fills and stalls the request side.
	initial begin
		while (n_accepted < 300) @(posedge clk);
		res_hold = 1'b1;
		repeat (150) @(posedge clk);
		res_hold = 1'b0;
	end

	// Monitor: checks each result, then predicts for each accepted request.
	always @(posedge clk) begin : monitor
		fault_result_t want;
		chk_fire = arst_n && chk.valid && chk.ready;
		if (arst_n && res.valid && res.ready) begin
			if (flags_due.size() == 0) begin
				$error("unexpected result: fault_flags %03h servo_disable %0b",
					res.fault_flags, res.servo_disable);
				errors++;
			end else begin
				want = flags_due.pop_front();
				if (res.fault_flags !== want.flags) begin
					$error("fault_flags: expected %03h, actual %03h", want.flags,
						res.fault_flags);
					errors++;
				end
				if (res.servo_disable !== want.servo_disable) begin
					$error("servo_disable: expected %0b, actual %0b", want.servo_disable,
						res.servo_disable);
					errors++;
				end
			end
		end
		if (chk_fire) begin
			flags_due.push_back(predict_faults(check_queue[0]));
			void'(check_queue.pop_front());
			n_accepted++;
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Main sequence: reset, directed requests, then randomized phases.
	initial begin
		logic [63:0] r64;
		check_req_t  it;

		arst_n          = 1'b0;
		chk.valid       = 1'b0;
		chk.req_type    = REQ_CHECK;
		chk.dc_link     = '0;
		chk.pwr_temp    = '0;
		chk.ctrl_temp   = '0;
		chk.speed_ref   = '0;
		chk.current_a   = '0;
		chk.current_b   = '0;
		chk.phase_found = 1'b0;
		res.ready       = 1'b0;
		cfg.valid       = 1'b0;
		cfg.index       = REG_DC_UPPER;
		cfg.data        = '0;

		lim_dc_upper  = RST_DC_UPPER;
		lim_dc_lower  = RST_DC_LOWER;
		lim_dev_upper = RST_DEV_UPPER;
		lim_dev_lower = RST_DEV_LOWER;
		lim_dsp_upper = RST_DSP_UPPER;
		lim_dsp_lower = RST_DSP_LOWER;
		lim_cont_sq   = RST_CONT_SQ;
		lim_overload  = RST_OVL_LIMIT;
		for (int i = 0; i < NUM_CHECKS; i++) begin
			trip_cnt[i] = '0;
		end
		i2t_accum   = '0;
		fault_state = '0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests at the reset limits: thresholds, field extremes,
		// speed magnitude of the most negative value, a debounced over-voltage,
		// the phase-finding disable, and clears.
		check_queue.push_back(nominal_check());
		it = nominal_check(); it.dc_link = 16'd4000; check_queue.push_back(it);
		it = nominal_check(); it.dc_link = 16'd1000; check_queue.push_back(it);
		it = nominal_check(); it.speed_ref = -16'sd32768; check_queue.push_back(it);
		it = nominal_check(); it.speed_ref = 16'sd3000; check_queue.push_back(it);
		it = nominal_check(); it.speed_ref = -16'sd3001; check_queue.push_back(it);
		it = nominal_check();
		it.pwr_temp = 16'sd32767; it.ctrl_temp = -16'sd32768;
		it.current_a = -16'sd32768; it.current_b = -16'sd32768;
		check_queue.push_back(it);
		it = nominal_check();
		it.pwr_temp = -16'sd32768; it.ctrl_temp = 16'sd32767;
		it.current_a = 16'sd32767; it.current_b = 16'sd32767;
		check_queue.push_back(it);
		it = nominal_check(); it.phase_found = 1'b0; check_queue.push_back(it);
		repeat (DEF_DC_COUNT) begin
			it = nominal_check(); it.dc_link = 16'hFFFF; check_queue.push_back(it);
		end
		it = nominal_check(); it.phase_found = 1'b0; check_queue.push_back(it);
		it = nominal_check(); it.kind = REQ_CLEAR; check_queue.push_back(it);
		it = nominal_check(); it.phase_found = 1'b0; check_queue.push_back(it);
		it = nominal_check(); it.dc_link = '0; it.speed_ref = 16'sd32767;
		check_queue.push_back(it);
		it = noise_req(); it.kind = REQ_CLEAR; check_queue.push_back(it);
		check_queue.push_back(nominal_check());
		drain();

		// Limits wide open; an overload limit of zero trips on any current.
		set_limits(65535, 0, 32767, -32768, 32767, -32768, '0, '0);
		queue_episodes(150);
		drain();

		// Limits closed; the rating swamps any current.
		set_limits(0, 65535, -32768, 32767, -32768, 32767, '1, '1);
		queue_episodes(100);
		drain();

		// Plausible random limits.
		repeat (4) begin
			r64 = {$urandom, $urandom};
			set_limits(rnd_in(1500, 8000), rnd_in(0, 1500), rnd_in(0, 1500),
				rnd_in(-1000, 0), rnd_in(0, 1500), rnd_in(-1000, 0),
				($urandom_range(3) == 0) ? $urandom : rnd_in(0, 1 << 20),
				LIMIT_W'(r64 >> (25 + $urandom_range(14))));
			queue_episodes(150);
			drain();
		end

		// Back to the reset limits, at full rate on both sides.
		quiet = 1'b1;
		set_limits(RST_DC_UPPER, RST_DC_LOWER, RST_DEV_UPPER, RST_DEV_LOWER, RST_DSP_UPPER,
			RST_DSP_LOWER, RST_CONT_SQ, RST_OVL_LIMIT);
		queue_episodes(100);
		drain();

		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
